[hw/rtl/aled_pkg.sv]
// Shared types and constants for the addressable LED bit serializer.
// Holds the word structs, phase codes, register indexes and reset values.
// No dependencies.
package aled_pkg;

  localparam int COLOR_BITS   = 24;
  localparam int CHAN_W       = 8;
  localparam int HIGH_W       = 16;
  localparam int GAP_W        = 20;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 20;

  // Phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_GAP  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_HIGH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ONE_HIGH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP        = 3'd4;

  // Register reset values
  localparam logic [CHAN_W-1:0] RST_BRIGHTNESS = 8'd20;
  localparam logic [HIGH_W-1:0] RST_ZERO_HIGH  = 16'd50;
  localparam logic [HIGH_W-1:0] RST_ONE_HIGH   = 16'd100;
  localparam logic [HIGH_W-1:0] RST_BIT_PERIOD = 16'd168;
  localparam logic [GAP_W-1:0]  RST_GAP        = 20'd168000;

  typedef struct packed {
    logic              load;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } in_word_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } out_word_t;

endpackage

[hw/rtl/aled_scale.sv]
// Brightness scaling of one color: each channel times brightness over 255.
// Packs the scaled channels green, red, blue into one 24-bit word.
// Depends on aled_pkg.
module aled_scale (
  input  logic [aled_pkg::CHAN_W-1:0]     brightness,
  input  logic [aled_pkg::CHAN_W-1:0]     red,
  input  logic [aled_pkg::CHAN_W-1:0]     green,
  input  logic [aled_pkg::CHAN_W-1:0]     blue,
  output logic [aled_pkg::COLOR_BITS-1:0] grb
);

  // Exact floor(v * b / 255) for 8-bit operands: (p + (p >> 8) + 1) >> 8.
  function automatic logic [aled_pkg::CHAN_W-1:0] scale_chan(
    input logic [aled_pkg::CHAN_W-1:0] v,
    input logic [aled_pkg::CHAN_W-1:0] b
  );
    logic [15:0] prod;
    logic [16:0] acc;
    prod = 16'(v) * 16'(b);
    acc  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    return acc[15:8];
  endfunction

  assign grb = {scale_chan(green, brightness),
                scale_chan(red, brightness),
                scale_chan(blue, brightness)};

endmodule

[hw/rtl/addressable_led_bit_serializer_unit.sv]
// Top level of the addressable LED bit serializer.
// Holds the timing registers, the phase sequencer and the output word register.
// Depends on aled_pkg and aled_scale.
//
//   channel  | direction | handshake           | word
//   ---------+-----------+---------------------+------------------------------
//   in       | into unit | in_valid/in_stall   | aled_pkg::in_word_t (one tick)
//   out      | out       | out_valid/out_stall | aled_pkg::out_word_t
//   cfg      | into unit | cfg_write           | cfg_index, cfg_data
//
// Every input word is one tick of line timing and yields exactly one output word.
// One word per cycle unless the output stalls: the sequencer advances in the same cycle
// a word is taken, and the result lands in the output register on the next edge.
// Input stalls only while the output register is full and its consumer stalls.
// Reset (rst, synchronous) returns all timing registers to their defaults and
// the sequencer to idle; no clearing pass is needed.
module addressable_led_bit_serializer_unit #(
  parameter int BITS_PER_FRAME = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  aled_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output aled_pkg::out_word_t                out_data,
  input  logic                               cfg_write,
  input  logic [aled_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [aled_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(BITS_PER_FRAME + 1);

  // Timing registers
  logic [aled_pkg::CHAN_W-1:0] brightness;
  logic [aled_pkg::HIGH_W-1:0] zero_high_cycles;
  logic [aled_pkg::HIGH_W-1:0] one_high_cycles;
  logic [aled_pkg::HIGH_W-1:0] bit_period_cycles;
  logic [aled_pkg::GAP_W-1:0]  gap_cycles;

  // Sequencer state
  logic [BITS_PER_FRAME-1:0]  color_shift, color_shift_next;
  logic [CNT_W-1:0]           bits_left, bits_left_next;
  logic [1:0]                 phase, phase_next;
  logic [aled_pkg::GAP_W-1:0] phase_count, phase_count_next;

  aled_pkg::out_word_t result;

  logic                          in_fire;
  logic [aled_pkg::COLOR_BITS-1:0] grb;
  logic [aled_pkg::HIGH_W-1:0]   high_len;
  logic [aled_pkg::HIGH_W-1:0]   low_len;
  logic [aled_pkg::HIGH_W-1:0]   high_lim;
  logic [aled_pkg::GAP_W-1:0]    gap_lim;
  logic [aled_pkg::GAP_W-1:0]    count_inc;
  logic [CNT_W-1:0]              bits_dec;

  // Hold the input while a finished word waits on a stalled consumer.
  assign in_stall = out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  // Configuration writes; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness        <= aled_pkg::RST_BRIGHTNESS;
      zero_high_cycles  <= aled_pkg::RST_ZERO_HIGH;
      one_high_cycles   <= aled_pkg::RST_ONE_HIGH;
      bit_period_cycles <= aled_pkg::RST_BIT_PERIOD;
      gap_cycles        <= aled_pkg::RST_GAP;
    end else if (cfg_write) begin
      case (cfg_index)
        aled_pkg::CFG_BRIGHTNESS: brightness        <= cfg_data[aled_pkg::CHAN_W-1:0];
        aled_pkg::CFG_ZERO_HIGH:  zero_high_cycles  <= cfg_data[aled_pkg::HIGH_W-1:0];
        aled_pkg::CFG_ONE_HIGH:   one_high_cycles   <= cfg_data[aled_pkg::HIGH_W-1:0];
        aled_pkg::CFG_BIT_PERIOD: bit_period_cycles <= cfg_data[aled_pkg::HIGH_W-1:0];
        aled_pkg::CFG_GAP:        gap_cycles        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scale the incoming color; only used on a load from idle.
  aled_scale u_scale (
    .brightness (brightness),
    .red        (in_data.red),
    .green      (in_data.green),
    .blue       (in_data.blue),
    .grb        (grb)
  );

  // Bit timing for the bit now at the head of the shift register.
  assign high_len  = color_shift[BITS_PER_FRAME-1] ? one_high_cycles : zero_high_cycles;
  assign high_lim  = (high_len == '0) ? aled_pkg::HIGH_W'(1) : high_len;
  assign low_len   = (bit_period_cycles > high_len) ? (bit_period_cycles - high_len) : '0;
  assign gap_lim   = (gap_cycles == '0) ? aled_pkg::GAP_W'(1) : gap_cycles;
  assign count_inc = phase_count + aled_pkg::GAP_W'(1);
  assign bits_dec  = (bits_left != '0) ? (bits_left - CNT_W'(1)) : '0;

  always_comb begin
    color_shift_next  = color_shift;
    bits_left_next    = bits_left;
    phase_next        = phase;
    phase_count_next  = count_inc;
    result.line_level = 1'b0;
    result.busy_res   = 1'b1;
    result.frame_done = 1'b0;
    case (phase)
      aled_pkg::PH_HIGH: begin
        result.line_level = 1'b1;
        if (count_inc >= aled_pkg::GAP_W'(high_lim)) begin
          phase_count_next = '0;
          if (low_len != '0) begin
            phase_next = aled_pkg::PH_LOW;
          end else begin
            // High time fills the period: skip the low part, advance the bit.
            color_shift_next = color_shift << 1;
            bits_left_next   = bits_dec;
            phase_next       = (bits_dec == '0) ? aled_pkg::PH_GAP : aled_pkg::PH_HIGH;
          end
        end
      end
      aled_pkg::PH_LOW: begin
        if (count_inc >= aled_pkg::GAP_W'(low_len)) begin
          color_shift_next = color_shift << 1;
          bits_left_next   = bits_dec;
          phase_count_next = '0;
          phase_next       = (bits_dec == '0) ? aled_pkg::PH_GAP : aled_pkg::PH_HIGH;
        end
      end
      aled_pkg::PH_GAP: begin
        if (count_inc >= gap_lim) begin
          result.frame_done = 1'b1;
          phase_next        = aled_pkg::PH_IDLE;
          phase_count_next  = '0;
        end
      end
      default: begin
        // Idle: latch a new frame on load, ignore otherwise.
        result.busy_res  = 1'b0;
        phase_count_next = phase_count;
        if (in_data.load) begin
          color_shift_next = BITS_PER_FRAME'(grb) << (BITS_PER_FRAME - aled_pkg::COLOR_BITS);
          bits_left_next   = CNT_W'(BITS_PER_FRAME);
          phase_next       = aled_pkg::PH_HIGH;
          phase_count_next = '0;
        end
      end
    endcase
  end

  // Advance the sequencer only on an accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_shift <= '0;
      bits_left   <= '0;
      phase       <= aled_pkg::PH_IDLE;
      phase_count <= '0;
    end else if (in_fire) begin
      color_shift <= color_shift_next;
      bits_left   <= bits_left_next;
      phase       <= phase_next;
      phase_count <= phase_count_next;
    end
  end

  // Output word register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result;
    end
  end

  // The line is never driven high outside a frame.
  a_line_busy : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.line_level |-> out_data.busy_res)
    else $error("line high while not busy");

  // Frame completion is reported only while busy.
  a_done_busy : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> out_data.busy_res)
    else $error("frame_done outside a frame");

  // A load taken from idle starts a full frame in the high phase.
  a_load_start : assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == aled_pkg::PH_IDLE && in_data.load
    |=> phase == aled_pkg::PH_HIGH && bits_left == CNT_W'(BITS_PER_FRAME))
    else $error("load did not start a frame");

  // The bit counter never exceeds the frame length.
  a_bits_range : assert property (@(posedge clk) disable iff (rst)
    bits_left <= CNT_W'(BITS_PER_FRAME))
    else $error("bit counter out of range");

endmodule

[test/tb.sv]
// Self-checking bench for addressable_led_bit_serializer_unit: a directed table, extreme settings, then
// random phases, each scored tick by tick against a local model of the line timing.
// Depends on aled_pkg and the RTL of the unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BITS  = 24;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 40;
  localparam int IDLE_PCT    = 11;
  localparam int CHOKE_LEN   = 48;
  localparam int DRAIN_TICKS = 8;
  localparam int STALL_LIMIT = 1000;

  // Indexes past the last register; writes to them must change nothing
  localparam logic [aled_pkg::CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [aled_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef enum logic [1:0] {ROW_TICK, ROW_RUN, ROW_SET} row_kind_t;

  typedef struct {
    row_kind_t                        kind;
    logic                             load;
    logic [aled_pkg::CHAN_W-1:0]      red;
    logic [aled_pkg::CHAN_W-1:0]      green;
    logic [aled_pkg::CHAN_W-1:0]      blue;
    int                               reps;
    logic [aled_pkg::CFG_INDEX_W-1:0] idx;
    logic [aled_pkg::CFG_DATA_W-1:0]  val;
    bit                               typed;
    aled_pkg::out_word_t              want;
  } dir_row_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  aled_pkg::in_word_t               in_data;
  logic                             out_valid;
  logic                             out_stall;
  aled_pkg::out_word_t              out_data;
  logic                             cfg_write;
  logic [aled_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [aled_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Local copy of the timing registers
  logic [aled_pkg::CHAN_W-1:0] reg_bright;
  logic [aled_pkg::HIGH_W-1:0] reg_zero_high;
  logic [aled_pkg::HIGH_W-1:0] reg_one_high;
  logic [aled_pkg::HIGH_W-1:0] reg_period;
  logic [aled_pkg::GAP_W-1:0]  reg_gap;

  // Local copy of the line sequencer
  logic [FRAME_BITS-1:0] lamp_shift;
  logic [5:0]            lamp_bits;
  logic [1:0]            lamp_phase;
  logic [31:0]           lamp_count;

  aled_pkg::out_word_t level_expect_q[$];
  bit        mismatch_seen = 1'b0;
  bit        steady        = 1'b0;
  bit        choke_req     = 1'b0;
  int        idle_run      = 0;

  // Table of directed words; rows with typed results need no model to read
  dir_row_t dir_rows [24] = '{
    // defaults after reset: idle words read back all low
    '{ROW_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b1, 3'b000},
    '{ROW_TICK, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b1, 3'b000},
    // full brightness, short bits, zero gap
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, aled_pkg::CFG_BRIGHTNESS, 20'd255, 1'b0, 3'b000},
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, aled_pkg::CFG_ZERO_HIGH,  20'd1, 1'b0, 3'b000},
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, aled_pkg::CFG_ONE_HIGH,   20'd2, 1'b0, 3'b000},
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, aled_pkg::CFG_BIT_PERIOD, 20'd3, 1'b0, 3'b000},
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, aled_pkg::CFG_GAP,        20'd0, 1'b0, 3'b000},
    // load on idle still reports idle; the line rises on the next word
    '{ROW_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b1, 3'b000},
    '{ROW_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b1, 3'b110},
    // loads while busy are dropped, then restart the frame once idle
    '{ROW_RUN,  1'b1, 8'h00, 8'h00, 8'h00, 90, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b0, 3'b000},
    // zero brightness sends an all-zero frame
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b0, 3'b000},
    '{ROW_TICK, 1'b1, 8'hFF, 8'h00, 8'hFF, 1, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b0, 3'b000},
    '{ROW_RUN,  1'b0, 8'h00, 8'h00, 8'h00, 40, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b0, 3'b000},
    // zero high time, one high past the period, short gap
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, aled_pkg::CFG_ZERO_HIGH,  20'd0, 1'b0, 3'b000},
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, aled_pkg::CFG_ONE_HIGH,   20'd5, 1'b0, 3'b000},
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, aled_pkg::CFG_BIT_PERIOD, 20'd4, 1'b0, 3'b000},
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, aled_pkg::CFG_GAP,        20'd3, 1'b0, 3'b000},
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, aled_pkg::CFG_BRIGHTNESS, 20'd128, 1'b0, 3'b000},
    '{ROW_TICK, 1'b1, 8'hA5, 8'h5A, 8'hFF, 1, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b0, 3'b000},
    '{ROW_RUN,  1'b0, 8'h3C, 8'hC3, 8'h81, 130, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b0, 3'b000},
    // writes past the last register leave every setting alone
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, CFG_SPARE_FIRST, 20'hFFFFF, 1'b0, 3'b000},
    '{ROW_SET,  1'b0, 8'h00, 8'h00, 8'h00, 0, CFG_SPARE_LAST,  20'h5A5A5, 1'b0, 3'b000},
    '{ROW_TICK, 1'b1, 8'h00, 8'hFF, 8'h01, 1, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b0, 3'b000},
    '{ROW_RUN,  1'b1, 8'h7E, 8'h81, 8'h00, 60, aled_pkg::CFG_BRIGHTNESS, 20'd0, 1'b0, 3'b000}
  };

  addressable_led_bit_serializer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scale one channel by brightness/255, truncated
  function automatic logic [aled_pkg::CHAN_W-1:0] scale_chan(
    input logic [aled_pkg::CHAN_W-1:0] v
  );
    logic [15:0] prod;
    prod = v * reg_bright;
    return aled_pkg::CHAN_W'(prod / 16'd255);
  endfunction

  // Drop the sent bit and move to the next one, or to the gap after the last
  function automatic void shift_lamp_bit();
    lamp_shift = lamp_shift << 1;
    lamp_count = 0;
    if (lamp_bits != 0) lamp_bits--;
    lamp_phase = (lamp_bits == 0) ? aled_pkg::PH_GAP : aled_pkg::PH_HIGH;
  endfunction

  // Report the line for the state at the start of the tick, then advance it
  function automatic aled_pkg::out_word_t advance_line(input aled_pkg::in_word_t w);
    aled_pkg::out_word_t         o;
    logic [aled_pkg::HIGH_W-1:0] hi;
    logic [aled_pkg::HIGH_W-1:0] lo;
    logic [31:0]                 lim;
    o = '0;
    o.busy_res = 1'b1;
    hi = lamp_shift[FRAME_BITS-1] ? reg_one_high : reg_zero_high;
    lo = (reg_period > hi) ? reg_period - hi : '0;
    case (lamp_phase)
      aled_pkg::PH_HIGH: begin
        o.line_level = 1'b1;
        lim = (hi == 0) ? 32'd1 : 32'(hi);
        lamp_count++;
        if (lamp_count >= lim) begin
          lamp_count = 0;
          if (lo != 0) lamp_phase = aled_pkg::PH_LOW;
          else shift_lamp_bit();
        end
      end
      aled_pkg::PH_LOW: begin
        lamp_count++;
        if (lamp_count >= 32'(lo)) shift_lamp_bit();
      end
      aled_pkg::PH_GAP: begin
        lim = (reg_gap == 0) ? 32'd1 : 32'(reg_gap);
        lamp_count++;
        if (lamp_count >= lim) begin
          o.frame_done = 1'b1;
          lamp_phase = aled_pkg::PH_IDLE;
          lamp_count = 0;
        end
      end
      default: begin
        o.busy_res = 1'b0;
        lamp_phase = aled_pkg::PH_IDLE;
        if (w.load) begin
          lamp_shift = FRAME_BITS'({scale_chan(w.green), scale_chan(w.red), scale_chan(w.blue)})
                       << (FRAME_BITS - aled_pkg::COLOR_BITS);
          lamp_bits  = 6'(FRAME_BITS);
          lamp_phase = aled_pkg::PH_HIGH;
          lamp_count = 0;
        end
      end
    endcase
    return o;
  endfunction

  function automatic aled_pkg::in_word_t random_word(input int load_pct);
    aled_pkg::in_word_t w;
    w.load  = ($urandom_range(99) < load_pct);
    w.red   = aled_pkg::CHAN_W'($urandom_range(255));
    w.green = aled_pkg::CHAN_W'($urandom_range(255));
    w.blue  = aled_pkg::CHAN_W'($urandom_range(255));
    return w;
  endfunction

  // Offer one word, hold it until taken, and queue its expected line word.
  // Called and left at a falling edge.
  task automatic push_word(input aled_pkg::in_word_t w, input bit typed,
                           input aled_pkg::out_word_t want);
    aled_pkg::out_word_t pred;
    cfg_write <= 1'b0;
    // idle now and then, never while the steady stretch runs
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = advance_line(w);
    level_expect_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Write one register and mirror it locally; the line must be idle here
  task automatic write_reg(input logic [aled_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [aled_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      aled_pkg::CFG_BRIGHTNESS: reg_bright    = val[aled_pkg::CHAN_W-1:0];
      aled_pkg::CFG_ZERO_HIGH:  reg_zero_high = val[aled_pkg::HIGH_W-1:0];
      aled_pkg::CFG_ONE_HIGH:   reg_one_high  = val[aled_pkg::HIGH_W-1:0];
      aled_pkg::CFG_BIT_PERIOD: reg_period    = val[aled_pkg::HIGH_W-1:0];
      aled_pkg::CFG_GAP:        reg_gap       = val[aled_pkg::GAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Finish any frame in flight with load low, then hold off until every
  // expected word is back
  task automatic park_line();
    aled_pkg::in_word_t w;
    while (lamp_phase != aled_pkg::PH_IDLE) begin
      w = random_word(0);
      push_word(w, 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (level_expect_q.size() != 0) @(negedge clk);
  endtask

  // Stimulus: reset, directed table, extreme settings, random phases
  initial begin
    aled_pkg::in_word_t w;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reg_bright    = aled_pkg::RST_BRIGHTNESS;
    reg_zero_high = aled_pkg::RST_ZERO_HIGH;
    reg_one_high  = aled_pkg::RST_ONE_HIGH;
    reg_period    = aled_pkg::RST_BIT_PERIOD;
    reg_gap       = aled_pkg::RST_GAP;
    lamp_shift = '0;
    lamp_bits  = '0;
    lamp_phase = aled_pkg::PH_IDLE;
    lamp_count = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      w = '{load: dir_rows[i].load, red: dir_rows[i].red,
            green: dir_rows[i].green, blue: dir_rows[i].blue};
      case (dir_rows[i].kind)
        ROW_SET: begin
          park_line();
          write_reg(dir_rows[i].idx, dir_rows[i].val);
        end
        default: begin
          repeat (dir_rows[i].reps) push_word(w, dir_rows[i].typed, dir_rows[i].want);
        end
      endcase
    end

    // Every register at its top value; a frame here would run far too long,
    // so just check a few idle words
    park_line();
    write_reg(aled_pkg::CFG_BRIGHTNESS, 20'd255);
    write_reg(aled_pkg::CFG_ZERO_HIGH,  20'd65535);
    write_reg(aled_pkg::CFG_ONE_HIGH,   20'd65535);
    write_reg(aled_pkg::CFG_BIT_PERIOD, 20'd65535);
    write_reg(aled_pkg::CFG_GAP,        20'hFFFFF);
    repeat (6) begin
      w = random_word(0);
      push_word(w, 1'b0, '0);
    end

    // Random phases, each with fresh short timing so many frames complete
    for (int p = 0; p < RAND_PHASES; p++) begin
      park_line();
      steady = (p == 2);
      if (p == 5) choke_req = 1'b1;
      case ($urandom_range(3))
        0:       write_reg(aled_pkg::CFG_BRIGHTNESS, 20'd0);
        1:       write_reg(aled_pkg::CFG_BRIGHTNESS, 20'd255);
        default: write_reg(aled_pkg::CFG_BRIGHTNESS,
                           aled_pkg::CFG_DATA_W'($urandom_range(255)));
      endcase
      write_reg(aled_pkg::CFG_ZERO_HIGH,  aled_pkg::CFG_DATA_W'($urandom_range(6)));
      write_reg(aled_pkg::CFG_ONE_HIGH,   aled_pkg::CFG_DATA_W'($urandom_range(7)));
      write_reg(aled_pkg::CFG_BIT_PERIOD, aled_pkg::CFG_DATA_W'($urandom_range(9)));
      write_reg(aled_pkg::CFG_GAP,        aled_pkg::CFG_DATA_W'($urandom_range(8)));
      if ($urandom_range(2) == 0)
        write_reg(aled_pkg::CFG_INDEX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                  aled_pkg::CFG_DATA_W'($urandom_range(20'hFFFFF)));
      // mostly loads so frames start right after each gap
      repeat (PHASE_WORDS) begin
        w = random_word(65);
        push_word(w, 1'b0, '0);
      end
    end
    steady = 1'b0;

    // Drain, then let the pipe settle
    park_line();
    repeat (DRAIN_TICKS) @(negedge clk);
    if (!mismatch_seen && level_expect_q.size() == 0)
      $display("addressable_led_bit_serializer_unit regression: pass");
    else
      $display("addressable_led_bit_serializer_unit regression: fail");
    $finish;
  end

  // Line word sink: score each taken word, then pick the stall for the next cycle
  initial begin
    int                  choke_left;
    bit                  choke_taken;
    aled_pkg::out_word_t want;
    choke_left  = 0;
    choke_taken = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (level_expect_q.size() == 0) begin
          $error("line word with nothing expected: %b", out_data);
          mismatch_seen = 1'b1;
        end else begin
          want = level_expect_q.pop_front();
          if (out_data.line_level !== want.line_level) begin
            $error("line_level: expected %0b, got %0b", want.line_level, out_data.line_level);
            mismatch_seen = 1'b1;
          end
          if (out_data.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, out_data.busy_res);
            mismatch_seen = 1'b1;
          end
          if (out_data.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b", want.frame_done, out_data.frame_done);
            mismatch_seen = 1'b1;
          end
        end
      end
      @(negedge clk);
      // hold off once for a long stretch so the unit backs up into its input
      if (choke_req && !choke_taken) begin
        choke_taken = 1'b1;
        choke_left  = CHOKE_LEN;
      end
      if (choke_left > 0) choke_left--;
      out_stall <= (choke_left > 0) || (!steady && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: count cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("addressable_led_bit_serializer_unit regression: fail");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

endmodule

[files.f]
hw/rtl/aled_pkg.sv
hw/rtl/aled_scale.sv
hw/rtl/addressable_led_bit_serializer_unit.sv
test/tb.sv
